[sv/bqd_pkg.sv]
// Shared widths, codes, reset values and command bundle for the biquad filter.
package bqd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int ACC_WIDTH    = 32;
    localparam int PROD_WIDTH   = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int REG_IDX_W    = 3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // Coefficient values after reset (Q.8)
    localparam logic signed [COEF_WIDTH-1:0] B0_RST = 16'sd140;
    localparam logic signed [COEF_WIDTH-1:0] B1_RST = -16'sd280;
    localparam logic signed [COEF_WIDTH-1:0] B2_RST = 16'sd140;
    localparam logic signed [COEF_WIDTH-1:0] A1_RST = 16'sd225;
    localparam logic signed [COEF_WIDTH-1:0] A2_RST = -16'sd80;

    // Per-sample phases of the shared multiplier, in issue order
    typedef logic [2:0] t_phase;
    localparam t_phase PH_B0 = 3'd0;   // b0*x  -> y
    localparam t_phase PH_B2 = 3'd1;   // b2*x  -> start of new delay one
    localparam t_phase PH_B1 = 3'd2;   // b1*x  -> start of new delay two
    localparam t_phase PH_A2 = 3'd3;   // a2*y16 added into new delay one
    localparam t_phase PH_A1 = 3'd4;   // a1*y16 closes new delay two, commit

    // Controller to datapath commands
    typedef struct packed {
        logic   cap;       // capture the input item
        logic   mul_en;    // multiply stage active
        t_phase mul_ph;
        logic   mul_smp;   // 0: first sample, 1: second sample
        logic   acc_en;    // accumulate stage active
        t_phase acc_ph;
        logic   acc_smp;
        logic   load_out;  // copy results into the output register
    } t_cmd;

endpackage

[sv/bqd_if.sv]
// Handshake channel interfaces: sample input, filtered output, coefficient writes.
interface bqd_smp_if import bqd_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_first;
    logic signed [SAMPLE_WIDTH-1:0] sample_second;

    modport source (output valid, sample_first, sample_second, input ready);
    modport sink   (input valid, sample_first, sample_second, output ready);
endinterface

interface bqd_flt_if import bqd_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_first;
    logic signed [SAMPLE_WIDTH-1:0] filtered_second;

    modport source (output valid, filtered_first, filtered_second, input ready);
    modport sink   (input valid, filtered_first, filtered_second, output ready);
endinterface

interface bqd_cfg_if import bqd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [COEF_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/bqd_dp.sv]
// Datapath: coefficient registers, shared multiplier, accumulator and delays.
module bqd_dp import bqd_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  logic                           i_cfg_we,
    input  logic [REG_IDX_W-1:0]           i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x0,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1,
    output logic signed [SAMPLE_WIDTH-1:0] o_y0,
    output logic signed [SAMPLE_WIDTH-1:0] o_y1
);

    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [SAMPLE_WIDTH-1:0] r_x0, r_x1;
    logic signed [PROD_WIDTH-1:0]   r_prod;
    logic [ACC_WIDTH-1:0]           r_y, r_n1, r_n2, r_d1, r_d2;
    logic [SAMPLE_WIDTH-1:0]        r_res0, r_res1, r_out0, r_out1;

    logic signed [COEF_WIDTH-1:0]   s_coef;
    logic signed [SAMPLE_WIDTH-1:0] s_opd;
    logic signed [SAMPLE_WIDTH-1:0] s_y16;
    logic [ACC_WIDTH-1:0]           s_sh;
    logic [ACC_WIDTH-1:0]           s_y_sum;

    assign s_y16   = signed'(r_y[SAMPLE_WIDTH-1:0]);
    // Product scaled back to Q.0, floor rounding, sign-extended to the accumulator
    assign s_sh    = ACC_WIDTH'(r_prod >>> FRAC_BITS);
    assign s_y_sum = r_d2 + s_sh;

    // Coefficient and operand selection for the multiply stage
    always_comb begin
        s_coef = r_b0;
        s_opd  = i_cmd.mul_smp ? r_x1 : r_x0;
        case (i_cmd.mul_ph)
            PH_B0: s_coef = r_b0;
            PH_B2: s_coef = r_b2;
            PH_B1: s_coef = r_b1;
            PH_A2: begin
                s_coef = r_a2;
                s_opd  = s_y16;
            end
            PH_A1: begin
                s_coef = r_a1;
                s_opd  = s_y16;
            end
            default: s_coef = r_b0;
        endcase
    end

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RST;
            r_b1 <= B1_RST;
            r_b2 <= B2_RST;
            r_a1 <= A1_RST;
            r_a2 <= A2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:  r_b0 <= signed'(i_cfg_data);
                REG_B1:  r_b1 <= signed'(i_cfg_data);
                REG_B2:  r_b2 <= signed'(i_cfg_data);
                REG_A1:  r_a1 <= signed'(i_cfg_data);
                REG_A2:  r_a2 <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Filter state: the two delays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_cmd.acc_en && i_cmd.acc_ph == PH_A1) begin
            r_d2 <= r_n2 + s_sh;
            r_d1 <= r_n1;
        end
    end

    // Input capture, multiplier register, accumulations and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_x0 <= i_x0;
            r_x1 <= i_x1;
        end
        if (i_cmd.mul_en) begin
            r_prod <= s_coef * s_opd;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.acc_ph)
                PH_B0: begin
                    r_y <= s_y_sum;
                    if (i_cmd.acc_smp) begin
                        r_res1 <= s_y_sum[SAMPLE_WIDTH-1:0];
                    end else begin
                        r_res0 <= s_y_sum[SAMPLE_WIDTH-1:0];
                    end
                end
                PH_B2:   r_n1 <= s_sh;
                PH_B1:   r_n2 <= r_d1 + s_sh;
                PH_A2:   r_n1 <= r_n1 + s_sh;
                default: ;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out0 <= r_res0;
            r_out1 <= r_res1;
        end
    end

    assign o_y0 = signed'(r_out0);
    assign o_y1 = signed'(r_out1);

endmodule

[sv/bqd_ctrl.sv]
// Controller: sequences the shared multiplier and accumulator and owns the handshakes.
module bqd_ctrl import bqd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_mul_en, n_mul_en;
    t_phase     r_ph, n_ph;
    logic       r_smp, n_smp;
    logic       r_acc_en;
    t_phase     r_acc_ph;
    logic       r_acc_smp;
    logic       r_out_vld, n_out_vld;

    logic s_last_acc;
    logic s_can_load;

    assign s_last_acc = r_acc_en && r_acc_ph == PH_A1 && r_acc_smp;
    assign s_can_load = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_mul_en       = r_mul_en;
        n_ph           = r_ph;
        n_smp          = r_smp;
        o_cmd          = '0;
        o_cmd.cap      = i_in_valid && o_in_ready;
        o_cmd.mul_en   = r_mul_en;
        o_cmd.mul_ph   = r_ph;
        o_cmd.mul_smp  = r_smp;
        o_cmd.acc_en   = r_acc_en;
        o_cmd.acc_ph   = r_acc_ph;
        o_cmd.acc_smp  = r_acc_smp;

        // walk five phases for the first sample, then five for the second
        if (r_mul_en) begin
            if (r_ph == PH_A1) begin
                n_ph = PH_B0;
                if (r_smp) begin
                    n_mul_en = 1'b0;
                end else begin
                    n_smp = 1'b1;
                end
            end else begin
                n_ph = r_ph + 3'd1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (o_cmd.cap) begin
                    n_state  = ST_RUN;
                    n_mul_en = 1'b1;
                    n_ph     = PH_B0;
                    n_smp    = 1'b0;
                end
            end
            ST_RUN: begin
                if (s_last_acc) begin
                    if (s_can_load) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (s_can_load) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_vld = o_cmd.load_out ? 1'b1 : (r_out_vld && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mul_en  <= 1'b0;
            r_ph      <= PH_B0;
            r_smp     <= 1'b0;
            r_acc_en  <= 1'b0;
            r_acc_ph  <= PH_B0;
            r_acc_smp <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mul_en  <= n_mul_en;
            r_ph      <= n_ph;
            r_smp     <= n_smp;
            // accumulate stage runs in the cycle after the multiplier stage
            r_acc_en  <= r_mul_en;
            r_acc_ph  <= r_ph;
            r_acc_smp <= r_smp;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

[sv/biquad_iir_q8_two_sample_top.sv]
// Top level of the two-sample Q.8 transposed-form biquad filter.
//
// Channels: i_smp takes one item of two signed 16-bit samples (first, then
// second); o_flt returns one item with the low 16 bits of the filter output
// for each; i_cfg writes coefficient b0, b1, b2, a1, a2 at index 0..4
// (other indexes are ignored) and is always ready. Coefficients are Q.8.
// A single 16x16 multiplier is shared by the five products of each sample,
// ten issued in turn per item, followed by the accumulate of the last product
// and the return to idle. Input ready is high only in idle, so a new item is
// taken only after the previous one has been worked on.
// Reset (synchronous, active low) clears both delays, restores the default
// coefficients and empties the output register.
// Receiver stall: the finished item sits in the output register; a new input
// item is still taken and worked on, and its result waits in the datapath
// until the output register is free. Input ready is low meanwhile.
module biquad_iir_q8_two_sample_top import bqd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bqd_smp_if.sink   i_smp,
    bqd_flt_if.source o_flt,
    bqd_cfg_if.sink   i_cfg
);

    t_cmd s_cmd;
    logic s_in_ready;
    logic s_out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = s_in_ready;
    assign o_flt.valid = s_out_valid;

    bqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (s_in_ready),
        .o_out_valid (s_out_valid),
        .i_out_ready (o_flt.ready),
        .o_cmd       (s_cmd)
    );

    bqd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_x0       (i_smp.sample_first),
        .i_x1       (i_smp.sample_second),
        .o_y0       (o_flt.filtered_first),
        .o_y1       (o_flt.filtered_second)
    );

    // An accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && s_in_ready) |=> !s_in_ready)
        else $error("input ready right after an accepted item");

    // The output register is never reloaded while it holds an untaken item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |-> (!s_out_valid || o_flt.ready))
        else $error("output overwritten while stalled");

    // Arithmetic only runs while the input is closed
    a_work_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.mul_en || s_cmd.acc_en) |-> !s_in_ready)
        else $error("datapath active while accepting input");

endmodule

[verif/tb_biquad_iir_q8_two_sample_top.sv]
// Self-checking testbench for the two-sample Q.8 biquad filter top level.
module tb_biquad_iir_q8_two_sample_top;
    import bqd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int TIMEOUT_CYCLES   = 1_000_000;
    localparam int SETTLE_CYCLES    = 24;
    localparam int DIR_ROWS         = 24;
    localparam int MAX_SET_ROW      = 12;
    localparam int MIN_SET_ROW      = 18;
    localparam int RAND_PHASES      = 8;
    localparam int ITEMS_PER_PHASE  = 154;
    localparam int HOLD_AFTER       = 500;    // results seen before the long hold
    localparam int HOLD_CYCLES      = 300;
    localparam int MAX_PRINTED      = 50;

    // Register indexes past the coefficient list; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum {
        CS_DEFAULT, CS_ZERO, CS_PASS, CS_FULL, CS_GENTLE, CS_MAX, CS_MIN
    } coef_mix_e;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] first;
        logic signed [SAMPLE_WIDTH-1:0] second;
    } filt_pair_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] first;
        logic signed [SAMPLE_WIDTH-1:0] second;
        logic                           typed;
        logic signed [SAMPLE_WIDTH-1:0] want_first;
        logic signed [SAMPLE_WIDTH-1:0] want_second;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bqd_smp_if smp_ch ();
    bqd_flt_if flt_ch ();
    bqd_cfg_if cfg_ch ();

    biquad_iir_q8_two_sample_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_flt   (flt_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Directed items: only the first two after reset carry a hand-worked answer
    stim_row_t dir_rows [DIR_ROWS] = '{
        // default coefficients
        '{16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh0000, 1'b1, -16'sd17920, 16'sd20090},
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'sh0001, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0001, 16'shFFFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh5555, 16'shAAAA, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shAAAA, 16'sh5555, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0100, 16'shFF00, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        // all coefficients at the positive limit
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'shFFFF, 1'b0, 16'sh0000, 16'sh0000},
        // all coefficients at the negative limit
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0001, 16'sh0001, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000}
    };

    coef_mix_e phase_mix [RAND_PHASES] = '{
        CS_DEFAULT, CS_GENTLE, CS_FULL, CS_PASS, CS_MAX, CS_GENTLE, CS_FULL, CS_ZERO
    };

    // Filter model state: coefficients and the two transposed delays
    logic signed [COEF_WIDTH-1:0] tap_b0 = B0_RST;
    logic signed [COEF_WIDTH-1:0] tap_b1 = B1_RST;
    logic signed [COEF_WIDTH-1:0] tap_b2 = B2_RST;
    logic signed [COEF_WIDTH-1:0] fb_a1  = A1_RST;
    logic signed [COEF_WIDTH-1:0] fb_a2  = A2_RST;
    logic [ACC_WIDTH-1:0]         z1_acc = '0;
    logic [ACC_WIDTH-1:0]         z2_acc = '0;

    filt_pair_t pending_outputs [$];

    int  mismatches      = 0;
    int  items_taken     = 0;
    int  results_checked = 0;
    int  coef_writes     = 0;
    bit  tx_gap_on       = 1'b1;
    bit  rx_stall_on     = 1'b1;
    bit  hold_done       = 1'b0;

    // Q.8 product: exact, then arithmetic shift, sign-extended to the accumulator
    function automatic logic [ACC_WIDTH-1:0] q8_product(
        input logic signed [COEF_WIDTH-1:0]   c,
        input logic signed [SAMPLE_WIDTH-1:0] v
    );
        logic signed [PROD_WIDTH-1:0] p;
        p = c * v;
        return ACC_WIDTH'(p >>> FRAC_BITS);
    endfunction

    // One sample through the delays; feedback uses only the truncated output
    function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
        input logic signed [SAMPLE_WIDTH-1:0] x
    );
        logic [ACC_WIDTH-1:0]           y;
        logic signed [SAMPLE_WIDTH-1:0] y_short;
        logic [ACC_WIDTH-1:0]           next_z1;
        logic [ACC_WIDTH-1:0]           next_z2;
        y       = z2_acc + q8_product(tap_b0, x);
        y_short = y[SAMPLE_WIDTH-1:0];
        next_z1 = q8_product(tap_b2, x) + q8_product(fb_a2, y_short);
        next_z2 = z1_acc + q8_product(tap_b1, x) + q8_product(fb_a1, y_short);
        z1_acc  = next_z1;
        z2_acc  = next_z2;
        return y_short;
    endfunction

    function automatic void apply_coef(input logic [REG_IDX_W-1:0] idx,
                                       input logic [COEF_WIDTH-1:0] value);
        case (idx)
            REG_B0: tap_b0 = value;
            REG_B1: tap_b1 = value;
            REG_B2: tap_b2 = value;
            REG_A1: fb_a1  = value;
            REG_A2: fb_a2  = value;
            default: ;  // out-of-list index: dropped
        endcase
    endfunction

    function automatic logic [COEF_WIDTH-1:0] coef_for(input coef_mix_e mix,
                                                       input logic [REG_IDX_W-1:0] idx);
        case (mix)
            CS_DEFAULT: begin
                case (idx)
                    REG_B0:  return B0_RST;
                    REG_B1:  return B1_RST;
                    REG_B2:  return B2_RST;
                    REG_A1:  return A1_RST;
                    default: return A2_RST;
                endcase
            end
            CS_PASS:   return (idx == REG_B0) ? 16'sd256 : 16'sd0;
            CS_FULL:   return COEF_WIDTH'($urandom);
            CS_GENTLE: return COEF_WIDTH'(int'($urandom_range(0, 511)) - 256);
            CS_MAX:    return 16'sh7FFF;
            CS_MIN:    return 16'sh8000;
            default:   return '0;
        endcase
    endfunction

    // Mostly full-range samples, with extremes and small values mixed in
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'shFFFF;
                default: return 16'sh0000;
            endcase
        end
        if (r <= 2)
            return SAMPLE_WIDTH'(int'($urandom_range(0, 511)) - 256);
        return SAMPLE_WIDTH'($urandom);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [SAMPLE_WIDTH-1:0] want,
                                   input logic [SAMPLE_WIDTH-1:0] got);
        if (mismatches < MAX_PRINTED)
            $display("ERROR result %0d %s: expected %h, got %h", idx, what, want, got);
        mismatches++;
    endtask

    task automatic check_result(input logic signed [SAMPLE_WIDTH-1:0] got_first,
                                input logic signed [SAMPLE_WIDTH-1:0] got_second);
        filt_pair_t want;
        if (pending_outputs.size() == 0) begin
            report_mismatch("arrived with nothing outstanding", results_checked,
                            '0, got_first);
        end else begin
            want = pending_outputs.pop_front();
            if (got_first !== want.first)
                report_mismatch("filtered_first", results_checked, want.first, got_first);
            if (got_second !== want.second)
                report_mismatch("filtered_second", results_checked, want.second,
                                got_second);
        end
        results_checked++;
    endtask

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx,
                              input logic [COEF_WIDTH-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_coef(idx, value);
        coef_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic load_coef_set(input coef_mix_e mix);
        for (int k = REG_B0; k <= REG_A2; k++)
            write_coef(REG_IDX_W'(k), coef_for(mix, REG_IDX_W'(k)));
    endtask

    // Offer one item; the expectation is worked out at the accepting edge
    task automatic send_pair(input logic signed [SAMPLE_WIDTH-1:0] a,
                             input logic signed [SAMPLE_WIDTH-1:0] b,
                             input logic typed,
                             input logic signed [SAMPLE_WIDTH-1:0] want_a,
                             input logic signed [SAMPLE_WIDTH-1:0] want_b);
        int         gap;
        filt_pair_t outp;
        gap = tx_gap_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            smp_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        smp_ch.valid         = 1'b1;
        smp_ch.sample_first  = a;
        smp_ch.sample_second = b;
        do @(posedge i_clk); while (!smp_ch.ready);
        outp.first  = filter_sample(a);
        outp.second = filter_sample(b);
        if (typed) begin
            outp.first  = want_a;
            outp.second = want_b;
        end
        pending_outputs.push_back(outp);
        items_taken++;
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_drained();
        @(negedge i_clk);
        smp_ch.valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: check at the rising edge, move ready at the falling edge
    initial begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        flt_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && flt_ch.valid && flt_ch.ready)
                check_result(flt_ch.filtered_first, flt_ch.filtered_second);
            @(negedge i_clk);
            if (!hold_done && results_checked == HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                flt_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                flt_ch.ready = 1'b0;
                stall_left--;
            end else begin
                flt_ch.ready = 1'b1;
                if (rx_stall_on && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus: directed table, then randomised coefficient phases
    initial begin
        i_rst_n              = 1'b0;
        smp_ch.valid         = 1'b0;
        smp_ch.sample_first  = '0;
        smp_ch.sample_second = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int row = 0; row < DIR_ROWS; row++) begin
            if (row == MAX_SET_ROW) begin
                wait_drained();
                load_coef_set(CS_MAX);
                write_coef(REG_SPARE_LO, 16'h0000);
            end
            if (row == MIN_SET_ROW) begin
                wait_drained();
                load_coef_set(CS_MIN);
                write_coef(REG_SPARE_HI, 16'h7FFF);
            end
            send_pair(dir_rows[row].first, dir_rows[row].second, dir_rows[row].typed,
                      dir_rows[row].want_first, dir_rows[row].want_second);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            load_coef_set(phase_mix[p]);
            if ($urandom_range(0, 1))
                write_coef(REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                           COEF_WIDTH'($urandom));
            // one phase runs flat out on both sides
            tx_gap_on   = (p != 2 && p != 4);
            rx_stall_on = (p != 4 && p != 6);
            repeat (ITEMS_PER_PHASE)
                send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items over %0d coefficient settings and %0d register writes.",
                 items_taken, RAND_PHASES + 3, coef_writes);
        $display("%0d results checked, including a %0d-cycle output hold; %0d mismatches.",
                 results_checked, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d results outstanding.", pending_outputs.size());
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
sv/bqd_pkg.sv
sv/bqd_if.sv
sv/bqd_dp.sv
sv/bqd_ctrl.sv
sv/biquad_iir_q8_two_sample_top.sv
verif/tb_biquad_iir_q8_two_sample_top.sv
